// ----- design/ldhf_pkg.sv -----
`default_nettype none

package ldhf_pkg;

  // Sizing
  localparam int HISTORY_DEPTH = 8;
  localparam int LANES         = 3;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int LANE_IDX_W    = (LANES > 1) ? $clog2(LANES) : 1;

  // Field widths
  localparam int LANE_W   = 3;
  localparam int STAT_W   = 3;
  localparam int OCC_IN_W = 11;
  localparam int VOL_IN_W = 13;
  localparam int OCC_W    = 10;
  localparam int VOL_W    = 12;
  localparam int THR_W    = 8;
  localparam int CODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OCC_W-1:0] OCC_MAX = 10'd1000;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCC_THR      = 2'd0,
    CFG_VOL_THR      = 2'd1,
    CFG_WORKING_CODE = 2'd2
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  OCC_THR_RESET = 8'd26;
  localparam logic [THR_W-1:0]  VOL_THR_RESET = 8'd26;
  localparam logic [CODE_W-1:0] CODE_RESET    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- design/ldhf_ctrl.sv -----
`default_nettype none

module ldhf_ctrl import ldhf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dp_cmd_t      cmd
);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;
  logic             out_free;

  // State, step counter and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        idx_next   = IDX_W'(1);
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (idx == IDX_W'(HISTORY_DEPTH - 1)) begin
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FINISH: begin
        // wait until the result register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result valid: set on finish, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/ldhf_datapath.sv -----
`default_nettype none

module ldhf_datapath import ldhf_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dp_cmd_t                      cmd,
  // configuration writes
  input  wire logic                         cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  // request fields
  input  wire logic [LANE_W-1:0]            lane,
  input  wire logic signed [STAT_W-1:0]     lead_status,
  input  wire logic signed [STAT_W-1:0]     trail_status,
  input  wire logic signed [OCC_IN_W-1:0]   lead_occ,
  input  wire logic signed [OCC_IN_W-1:0]   trail_occ,
  input  wire logic signed [VOL_IN_W-1:0]   lead_vol,
  input  wire logic signed [VOL_IN_W-1:0]   trail_vol,
  input  wire logic                         sample_time_valid,
  // result fields
  output logic [LANE_W-1:0]                 out_lane,
  output logic                              lead_occ_healthy,
  output logic                              trail_occ_healthy,
  output logic                              lead_vol_healthy,
  output logic                              trail_vol_healthy,
  output logic [OCC_W-1:0]                  fused_occ,
  output logic [VOL_W-1:0]                  fused_vol,
  output logic                              sample_replaced
);

  localparam int N = HISTORY_DEPTH - 1;

  // Relative change test: |a-b|*256 <= thr*b
  function automatic logic step_hit(input logic [VOL_W-1:0] a,
                                    input logic [VOL_W-1:0] b,
                                    input logic [THR_W-1:0] thr);
    logic [VOL_W-1:0]       d;
    logic [VOL_W+THR_W-1:0] lhs;
    logic [VOL_W+THR_W-1:0] rhs;
    d   = (a > b) ? (a - b) : (b - a);
    lhs = {d, {THR_W{1'b0}}};
    rhs = (VOL_W+THR_W)'(thr) * (VOL_W+THR_W)'(b);
    return lhs <= rhs;
  endfunction

  // Configuration registers
  logic [THR_W-1:0]  occ_thr, vol_thr;
  logic [CODE_W-1:0] working_code;

  // Per-lane state
  logic [OCC_W-1:0]  lo_hist   [0:LANES-1][0:HISTORY_DEPTH-1];
  logic [OCC_W-1:0]  to_hist   [0:LANES-1][0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  lv_hist   [0:LANES-1][0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  tv_hist   [0:LANES-1][0:HISTORY_DEPTH-1];
  logic              tval_hist [0:LANES-1][0:HISTORY_DEPTH-1];
  logic [CODE_W-1:0] last_ls   [0:LANES-1];
  logic [CODE_W-1:0] last_ts   [0:LANES-1];
  logic [VOL_W-1:0]  kept_vol  [0:LANES-1];

  // Captured request
  logic [LANE_W-1:0]          lane_q;
  logic [STAT_W-1:0]          ls_q, ts_q;
  logic [OCC_IN_W-1:0]        lo_q, to_q;
  logic [VOL_IN_W-1:0]        lv_q, tv_q;
  logic                       tval_q;

  // Working window of the current lane
  logic [OCC_W-1:0]  wlo [0:HISTORY_DEPTH-1];
  logic [OCC_W-1:0]  wto [0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  wlv [0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  wtv [0:HISTORY_DEPTH-1];
  logic              wtval [0:HISTORY_DEPTH-1];
  logic              lstat, tstat;
  logic [IDX_W-1:0]  cnt_lo, cnt_to, cnt_lv, cnt_tv;
  logic              new_lo, new_to, new_lv, new_tv;

  // Shifted window built from the stored row
  logic [OCC_W-1:0]  sh_lo [0:HISTORY_DEPTH-1];
  logic [OCC_W-1:0]  sh_to [0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  sh_lv [0:HISTORY_DEPTH-1];
  logic [VOL_W-1:0]  sh_tv [0:HISTORY_DEPTH-1];
  logic              sh_tval [0:HISTORY_DEPTH-1];
  logic [CODE_W-1:0] ls_new, ts_new;

  logic                  lane_ok;
  logic [LANE_IDX_W-1:0] row;
  logic                  repl;
  logic [OCC_W-1:0]      lo_sat, to_sat;

  assign lane_ok = ({1'b0, lane_q} < (LANE_W+1)'(LANES));
  assign row     = lane_ok ? lane_q[LANE_IDX_W-1:0] : '0;
  assign repl    = ls_q[STAT_W-1] || ts_q[STAT_W-1] || lo_q[OCC_IN_W-1] ||
                   to_q[OCC_IN_W-1] || lv_q[VOL_IN_W-1] || tv_q[VOL_IN_W-1];

  // Occupancy saturation (only used when the reading is non-negative)
  assign lo_sat = (lo_q[OCC_IN_W-2:0] > OCC_MAX) ? OCC_MAX : lo_q[OCC_W-1:0];
  assign to_sat = (to_q[OCC_IN_W-2:0] > OCC_MAX) ? OCC_MAX : to_q[OCC_W-1:0];

  // Window shift; a replaced sample keeps the previous newest entry
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sh_lo[i]   = lo_hist[row][i+1];
      sh_to[i]   = to_hist[row][i+1];
      sh_lv[i]   = lv_hist[row][i+1];
      sh_tv[i]   = tv_hist[row][i+1];
      sh_tval[i] = tval_hist[row][i+1];
    end
    sh_lo[N]   = repl ? lo_hist[row][N] : lo_sat;
    sh_to[N]   = repl ? to_hist[row][N] : to_sat;
    sh_lv[N]   = repl ? lv_hist[row][N] : lv_q[VOL_W-1:0];
    sh_tv[N]   = repl ? tv_hist[row][N] : tv_q[VOL_W-1:0];
    sh_tval[N] = tval_q;
    ls_new     = repl ? last_ls[row] : ls_q[CODE_W-1:0];
    ts_new     = repl ? last_ts[row] : ts_q[CODE_W-1:0];
  end

  // One adjacent pair per step
  logic [IDX_W-1:0] jm1;
  logic             hit_lo, hit_to, hit_lv, hit_tv;

  assign jm1    = cmd.idx - 1'b1;
  assign hit_lo = wtval[cmd.idx] &&
                  step_hit(VOL_W'(wlo[cmd.idx]), VOL_W'(wlo[jm1]), occ_thr);
  assign hit_to = wtval[cmd.idx] &&
                  step_hit(VOL_W'(wto[cmd.idx]), VOL_W'(wto[jm1]), occ_thr);
  assign hit_lv = wtval[cmd.idx] && step_hit(wlv[cmd.idx], wlv[jm1], vol_thr);
  assign hit_tv = wtval[cmd.idx] && step_hit(wtv[cmd.idx], wtv[jm1], vol_thr);

  // Health decision and fusion
  logic             h_lo, h_to, h_lv, h_tv;
  logic [OCC_W:0]   occ_sum;
  logic [VOL_W:0]   vol_sum;
  logic [OCC_W-1:0] focc;
  logic [VOL_W-1:0] fvol;

  always_comb begin
    h_lo = lane_ok && lstat && !((cnt_lo > IDX_W'(N / 2)) && new_lo);
    h_to = lane_ok && tstat && !((cnt_to > IDX_W'(N / 2)) && new_to);
    h_lv = lane_ok && lstat && !((cnt_lv > IDX_W'(N / 2)) && new_lv);
    h_tv = lane_ok && tstat && !((cnt_tv > IDX_W'(N / 2)) && new_tv);
    occ_sum = {1'b0, wlo[N]} + {1'b0, wto[N]};
    vol_sum = {1'b0, wlv[N]} + {1'b0, wtv[N]};
    if (h_lo && h_to) begin
      focc = occ_sum[OCC_W:1];
    end else if (h_lo) begin
      focc = wlo[N];
    end else if (h_to) begin
      focc = wto[N];
    end else begin
      focc = '0;
    end
    if (h_lv && h_tv) begin
      fvol = vol_sum[VOL_W:1];
    end else if (h_lv) begin
      fvol = wlv[N];
    end else if (h_tv) begin
      fvol = wtv[N];
    end else if (lane_ok) begin
      fvol = kept_vol[row];
    end else begin
      fvol = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_thr      <= OCC_THR_RESET;
      vol_thr      <= VOL_THR_RESET;
      working_code <= CODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OCC_THR:      occ_thr      <= cfg_data[THR_W-1:0];
        CFG_VOL_THR:      vol_thr      <= cfg_data[THR_W-1:0];
        CFG_WORKING_CODE: working_code <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-lane history, statuses and kept volume
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          lo_hist[l][i]   <= '0;
          to_hist[l][i]   <= '0;
          lv_hist[l][i]   <= '0;
          tv_hist[l][i]   <= '0;
          tval_hist[l][i] <= 1'b0;
        end
        last_ls[l]  <= '0;
        last_ts[l]  <= '0;
        kept_vol[l] <= '0;
      end
    end else begin
      if (cmd.load && lane_ok) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          lo_hist[row][i]   <= sh_lo[i];
          to_hist[row][i]   <= sh_to[i];
          lv_hist[row][i]   <= sh_lv[i];
          tv_hist[row][i]   <= sh_tv[i];
          tval_hist[row][i] <= sh_tval[i];
        end
        last_ls[row] <= ls_new;
        last_ts[row] <= ts_new;
      end
      if (cmd.finish && lane_ok) begin
        kept_vol[row] <= fvol;
      end
    end
  end

  // Request capture and working window
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lane_q <= lane;
      ls_q   <= lead_status;
      ts_q   <= trail_status;
      lo_q   <= lead_occ;
      to_q   <= trail_occ;
      lv_q   <= lead_vol;
      tv_q   <= trail_vol;
      tval_q <= sample_time_valid;
    end
    if (cmd.load) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        wlo[i]   <= sh_lo[i];
        wto[i]   <= sh_to[i];
        wlv[i]   <= sh_lv[i];
        wtv[i]   <= sh_tv[i];
        wtval[i] <= sh_tval[i];
      end
      lstat  <= (ls_new == working_code);
      tstat  <= (ts_new == working_code);
      cnt_lo <= '0;
      cnt_to <= '0;
      cnt_lv <= '0;
      cnt_tv <= '0;
      new_lo <= 1'b0;
      new_to <= 1'b0;
      new_lv <= 1'b0;
      new_tv <= 1'b0;
    end
    if (cmd.step) begin
      cnt_lo <= cnt_lo + IDX_W'(hit_lo);
      cnt_to <= cnt_to + IDX_W'(hit_to);
      cnt_lv <= cnt_lv + IDX_W'(hit_lv);
      cnt_tv <= cnt_tv + IDX_W'(hit_tv);
      if (cmd.idx == IDX_W'(N)) begin
        new_lo <= hit_lo;
        new_to <= hit_to;
        new_lv <= hit_lv;
        new_tv <= hit_tv;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_lane          <= lane_q;
      lead_occ_healthy  <= h_lo;
      trail_occ_healthy <= h_to;
      lead_vol_healthy  <= h_lv;
      trail_vol_healthy <= h_tv;
      fused_occ         <= focc;
      fused_vol         <= fvol;
      sample_replaced   <= lane_ok && repl;
    end
  end

endmodule

`default_nettype wire

// ----- design/loop_detector_health_fusion.sv -----
`default_nettype none

// Channel   Handshake                Payload
// in        in_valid / in_stall      lane, lead/trail status, occ, vol, sample_time_valid
// out       out_valid / out_stall    out_lane, four health flags, fused_occ, fused_vol,
//                                    sample_replaced
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data (cfg_ready always high)
//
// One request runs through accept, window load, one adjacent history pair per cycle
// over HISTORY_DEPTH-1 steps, and result write, in that order.
// The history walk goes through the shared compare step.
// Synchronous reset clears every lane's history, statuses and kept volume at once.
// A finished result sits in the output register; the next request is accepted
// meanwhile, and only its result write waits while out_stall holds the old one.

module loop_detector_health_fusion import ldhf_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [LANE_W-1:0]           lane,
  input  wire logic signed [STAT_W-1:0]    lead_status,
  input  wire logic signed [STAT_W-1:0]    trail_status,
  input  wire logic signed [OCC_IN_W-1:0]  lead_occ,
  input  wire logic signed [OCC_IN_W-1:0]  trail_occ,
  input  wire logic signed [VOL_IN_W-1:0]  lead_vol,
  input  wire logic signed [VOL_IN_W-1:0]  trail_vol,
  input  wire logic                        sample_time_valid,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [LANE_W-1:0]                out_lane,
  output logic                             lead_occ_healthy,
  output logic                             trail_occ_healthy,
  output logic                             lead_vol_healthy,
  output logic                             trail_vol_healthy,
  output logic [OCC_W-1:0]                 fused_occ,
  output logic [VOL_W-1:0]                 fused_vol,
  output logic                             sample_replaced,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ldhf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ldhf_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .lane              (lane),
    .lead_status       (lead_status),
    .trail_status      (trail_status),
    .lead_occ          (lead_occ),
    .trail_occ         (trail_occ),
    .lead_vol          (lead_vol),
    .trail_vol         (trail_vol),
    .sample_time_valid (sample_time_valid),
    .out_lane          (out_lane),
    .lead_occ_healthy  (lead_occ_healthy),
    .trail_occ_healthy (trail_occ_healthy),
    .lead_vol_healthy  (lead_vol_healthy),
    .trail_vol_healthy (trail_vol_healthy),
    .fused_occ         (fused_occ),
    .fused_vol         (fused_vol),
    .sample_replaced   (sample_replaced)
  );

endmodule

`default_nettype wire
